@@ hdl/its_pkg.sv @@
package its_pkg;

	// Fixed field widths of the request and response words
	localparam int TAG_FIELD_W  = 16;
	localparam int TIME_FIELD_W = 63;
	localparam int SLOT_W       = 6;
	localparam int CALLS_W      = 32;

	typedef enum logic [1:0] {
		KIND_BEGIN = 2'd0,
		KIND_END   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_RESET = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RUNNING = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                    kind;
		logic [TAG_FIELD_W-1:0]   tag;
		logic [TIME_FIELD_W-1:0]  timestamp;
		logic [SLOT_W-1:0]        slot;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [SLOT_W-1:0]        entry;
		logic [TIME_FIELD_W-1:0]  duration;
		logic [TIME_FIELD_W-1:0]  min_first;
		logic [TIME_FIELD_W-1:0]  min_second;
		logic [TIME_FIELD_W-1:0]  max_first;
		logic [TIME_FIELD_W-1:0]  max_second;
		logic [TIME_FIELD_W-1:0]  total;
		logic [CALLS_W-1:0]       calls;
		logic                     running;
	} rsp_t;

endpackage

@@ hdl/its_ram.sv @@
module its_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/its_alu.sv @@
module its_alu #(
	parameter int W = 63
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);

	logic [W:0] full;

	// a + b, or a - b as a + ~b + 1; carry set means no borrow on subtract
	assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (W+1)'(sub);
	assign sum   = full[W-1:0];
	assign carry = full[W];

endmodule

@@ hdl/interval_timing_statistics.sv @@
// Channel | Dir | Handshake             | Word
// req     | in  | req_valid / req_stall | req_word (kind, tag, timestamp, slot)
// rsp     | out | rsp_valid / rsp_stall | rsp_word (status, entry, statistics)
//
// One request at a time; req_stall is high from acceptance until the response is queued.
// Begin/end scan one entry a cycle; an end that records runs six steps on the shared
// adder, then the write-back. A read loads the stored record; a reset of statistics
// clears each entry in use in turn. arst_n empties the table at once.
// A stalled response holds in the output register; the next request is taken meanwhile.
module interval_timing_statistics
	import its_pkg::*;
#(
	parameter int ENTRIES   = 64,
	parameter int TAG_BITS  = 16,
	parameter int TIME_BITS = 63
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_word,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	localparam int TAG_W = (TAG_BITS < TAG_FIELD_W) ? TAG_BITS : TAG_FIELD_W;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int NF_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W = (NF_W > SLOT_W) ? NF_W : SLOT_W;
	localparam int ST_W  = 1 + 6 * TIME_BITS + CALLS_W;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SCAN  = 13'b0000000000010,
		S_LOAD  = 13'b0000000000100,
		S_EVAL  = 13'b0000000001000,
		S_DUR   = 13'b0000000010000,
		S_MIN0  = 13'b0000000100000,
		S_MIN1  = 13'b0000001000000,
		S_MAX0  = 13'b0000010000000,
		S_MAX1  = 13'b0000100000000,
		S_TOT   = 13'b0001000000000,
		S_WRITE = 13'b0010000000000,
		S_CLEAR = 13'b0100000000000,
		S_DONE  = 13'b1000000000000
	} state_t;

	state_t               state_q;
	logic [NF_W-1:0]      next_free_q;
	logic                 cmp_ok_q;
	logic                 rsp_valid_q;

	kind_t                kind_q;
	logic [TAG_W-1:0]     tag_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     cmp_idx_q;
	logic [IDX_W-1:0]     e_q;
	logic [SLOT_W-1:0]    entry_q;
	status_t              status_q;
	logic                 zero_q;
	logic [TIME_BITS-1:0] dur_q;
	logic [TIME_BITS-1:0] c_q;
	logic                 running_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] min0_q;
	logic [TIME_BITS-1:0] min1_q;
	logic [TIME_BITS-1:0] max0_q;
	logic [TIME_BITS-1:0] max1_q;
	logic [TIME_BITS-1:0] total_q;
	logic [CALLS_W-1:0]   calls_q;
	rsp_t                 rsp_q;

	logic                 req_acc;
	logic                 rsp_load;
	logic                 slot_ok;
	logic                 table_full;
	logic                 tag_hit;
	logic                 scan_miss;
	logic                 clear_last;
	logic [TAG_W-1:0]     tag_rdata;
	logic                 tag_we;
	logic                 stat_we;
	logic [IDX_W-1:0]     stat_waddr;
	logic [ST_W-1:0]      stat_wdata;
	logic [ST_W-1:0]      stat_rdata;
	logic                 rd_running;
	logic [TIME_BITS-1:0] rd_start;
	logic [TIME_BITS-1:0] rd_min0;
	logic [TIME_BITS-1:0] rd_min1;
	logic [TIME_BITS-1:0] rd_max0;
	logic [TIME_BITS-1:0] rd_max1;
	logic [TIME_BITS-1:0] rd_total;
	logic [CALLS_W-1:0]   rd_calls;
	logic [TIME_BITS-1:0] alu_a;
	logic [TIME_BITS-1:0] alu_b;
	logic                 alu_sub;
	logic [TIME_BITS-1:0] alu_sum;
	logic                 alu_carry;
	rsp_t                 res;

	// Handshake
	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// Table occupancy and tag scan status
	assign slot_ok    = CMP_W'(req_word.slot) < CMP_W'(next_free_q);
	assign table_full = (next_free_q == NF_W'(ENTRIES));
	assign tag_hit    = cmp_ok_q && (tag_rdata == tag_q);
	assign scan_miss  = (next_free_q == '0) ||
	                    (cmp_ok_q && !tag_hit &&
	                     (NF_W'(cmp_idx_q) == next_free_q - NF_W'(1)));
	assign clear_last = (next_free_q == '0) ||
	                    (NF_W'(idx_q) == next_free_q - NF_W'(1));

	// Tag store: scanned at idx_q, written on allocation
	assign tag_we = (state_q == S_SCAN) && !tag_hit && scan_miss &&
	                (kind_q == KIND_BEGIN) && !table_full;

	its_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (next_free_q[IDX_W-1:0]),
		.wdata (tag_q),
		.raddr (idx_q),
		.rdata (tag_rdata)
	);

	// Statistics store: one record per entry
	assign stat_we    = (state_q == S_WRITE) ||
	                    ((state_q == S_CLEAR) && (next_free_q != '0));
	assign stat_waddr = (state_q == S_CLEAR) ? idx_q : e_q;
	assign stat_wdata = (state_q == S_CLEAR) ?
	                    {1'b0, {TIME_BITS{1'b0}}, {TIME_BITS{1'b1}}, {TIME_BITS{1'b1}},
	                     {TIME_BITS{1'b0}}, {TIME_BITS{1'b0}}, {TIME_BITS{1'b0}},
	                     {CALLS_W{1'b0}}} :
	                    {running_q, start_q, min0_q, min1_q, max0_q, max1_q,
	                     total_q, calls_q};
	assign {rd_running, rd_start, rd_min0, rd_min1, rd_max0, rd_max1,
	        rd_total, rd_calls} = stat_rdata;

	its_ram #(.WIDTH(ST_W), .DEPTH(ENTRIES)) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (stat_waddr),
		.wdata (stat_wdata),
		.raddr (e_q),
		.rdata (stat_rdata)
	);

	// Operand select for the shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_DUR: begin
				alu_a   = now_q;
				alu_b   = start_q;
				alu_sub = 1'b1;
			end
			S_MIN0: begin
				alu_a   = c_q;
				alu_b   = min0_q;
				alu_sub = 1'b1;
			end
			S_MIN1: begin
				alu_a   = c_q;
				alu_b   = min1_q;
				alu_sub = 1'b1;
			end
			S_MAX0: begin
				alu_a   = max0_q;
				alu_b   = c_q;
				alu_sub = 1'b1;
			end
			S_MAX1: begin
				alu_a   = max1_q;
				alu_b   = c_q;
				alu_sub = 1'b1;
			end
			S_TOT: begin
				alu_a   = total_q;
				alu_b   = dur_q;
				alu_sub = 1'b0;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	its_alu #(.W(TIME_BITS)) u_alu (
		.a     (alu_a),
		.b     (alu_b),
		.sub   (alu_sub),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	// Response word
	always_comb begin
		res        = '0;
		res.status = status_q;
		res.entry  = entry_q;
		if (!zero_q) begin
			res.duration   = TIME_FIELD_W'(dur_q);
			res.min_first  = TIME_FIELD_W'(min0_q);
			res.min_second = TIME_FIELD_W'(min1_q);
			res.max_first  = TIME_FIELD_W'(max0_q);
			res.max_second = TIME_FIELD_W'(max1_q);
			res.total      = TIME_FIELD_W'(total_q);
			res.calls      = calls_q;
			res.running    = running_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_free_q <= '0;
			cmp_ok_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					cmp_ok_q <= 1'b0;
					if (req_acc) begin
						case (req_word.kind) inside
							KIND_BEGIN, KIND_END: state_q <= S_SCAN;
							KIND_READ:            state_q <= slot_ok ? S_LOAD : S_DONE;
							default:              state_q <= S_CLEAR;
						endcase
					end
				end
				S_SCAN: begin
					cmp_ok_q <= 1'b1;
					if (tag_hit) begin
						state_q <= S_LOAD;
					end else if (scan_miss) begin
						if (tag_we) begin
							next_free_q <= next_free_q + NF_W'(1);
							state_q     <= S_WRITE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LOAD: state_q <= S_EVAL;
				S_EVAL: begin
					case (kind_q)
						KIND_BEGIN: state_q <= rd_running ? S_DONE : S_WRITE;
						KIND_END:   state_q <= rd_running ? S_DUR : S_DONE;
						default:    state_q <= S_DONE;
					endcase
				end
				S_DUR:   state_q <= S_MIN0;
				S_MIN0:  state_q <= S_MIN1;
				S_MIN1:  state_q <= S_MAX0;
				S_MAX0:  state_q <= S_MAX1;
				S_MAX1:  state_q <= S_TOT;
				S_TOT:   state_q <= S_WRITE;
				S_WRITE: state_q <= S_DONE;
				S_CLEAR: begin
					if (clear_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					kind_q   <= req_word.kind;
					tag_q    <= req_word.tag[TAG_W-1:0];
					now_q    <= req_word.timestamp[TIME_BITS-1:0];
					idx_q    <= '0;
					e_q      <= IDX_W'(req_word.slot);
					dur_q    <= '0;
					entry_q  <= (req_word.kind == KIND_READ) ? req_word.slot : '0;
					status_q <= ((req_word.kind == KIND_READ) && !slot_ok) ?
					            ST_UNKNOWN : ST_OK;
					zero_q   <= (req_word.kind == KIND_RESET) ||
					            ((req_word.kind == KIND_READ) && !slot_ok);
				end
			end
			S_SCAN: begin
				idx_q     <= idx_q + IDX_W'(1);
				cmp_idx_q <= idx_q;
				if (tag_hit) begin
					e_q     <= cmp_idx_q;
					entry_q <= SLOT_W'(cmp_idx_q);
				end else if (scan_miss) begin
					if (tag_we) begin
						// fresh entry, started at once
						e_q       <= next_free_q[IDX_W-1:0];
						entry_q   <= SLOT_W'(next_free_q);
						running_q <= 1'b1;
						start_q   <= now_q;
						min0_q    <= '1;
						min1_q    <= '1;
						max0_q    <= '0;
						max1_q    <= '0;
						total_q   <= '0;
						calls_q   <= '0;
					end else begin
						status_q <= (kind_q == KIND_BEGIN) ? ST_FULL : ST_UNKNOWN;
						zero_q   <= 1'b1;
					end
				end
			end
			S_EVAL: begin
				// a begin on an idle entry opens it at the request time
				running_q <= rd_running || (kind_q == KIND_BEGIN);
				start_q   <= ((kind_q == KIND_BEGIN) && !rd_running) ? now_q : rd_start;
				min0_q    <= rd_min0;
				min1_q    <= rd_min1;
				max0_q    <= rd_max0;
				max1_q    <= rd_max1;
				total_q   <= rd_total;
				calls_q   <= rd_calls;
				if ((kind_q == KIND_BEGIN) && rd_running) begin
					status_q <= ST_RUNNING;
				end
			end
			S_DUR: begin
				dur_q <= alu_sum;
				c_q   <= alu_sum;
			end
			// smaller pair: swap in when stored value exceeds the candidate
			S_MIN0: begin
				if (!alu_carry) begin
					min0_q <= c_q;
					c_q    <= min0_q;
				end
			end
			S_MIN1: begin
				if (!alu_carry) begin
					min1_q <= c_q;
				end
				c_q <= dur_q;
			end
			// larger pair: swap in when stored value is below the candidate
			S_MAX0: begin
				if (!alu_carry) begin
					max0_q <= c_q;
					c_q    <= max0_q;
				end
			end
			S_MAX1: begin
				if (!alu_carry) begin
					max1_q <= c_q;
				end
			end
			S_TOT: begin
				total_q   <= alu_carry ? '1 : alu_sum;
				calls_q   <= (calls_q == '1) ? calls_q : calls_q + CALLS_W'(1);
				running_q <= 1'b0;
				start_q   <= '0;
			end
			S_CLEAR: begin
				idx_q <= idx_q + IDX_W'(1);
			end
			S_DONE: begin
				if (rsp_load) begin
					rsp_q <= res;
				end
			end
			default: begin
				c_q <= c_q;
			end
		endcase
	end

endmodule

@@ hdl/its_chk.sv @@
module its_chk
	import its_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_word
);

	// A stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("response changed while stalled");

	// Every accepted request leaves the block busy in the following cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted on back-to-back cycles");

	// Pairs stay ordered
	a_pairs_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.min_first <= rsp_word.min_second) &&
		              (rsp_word.max_first >= rsp_word.max_second))
		else $error("min or max pair out of order");

	// Full table gives a word that is zero but for its status
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_word.status == ST_FULL) |->
		(rsp_word.entry == '0) && (rsp_word.calls == '0) && !rsp_word.running)
		else $error("table full response carries data");

	// A begin on a running entry reports it running
	a_running_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_word.status == ST_RUNNING) |-> rsp_word.running)
		else $error("already running without running flag");

endmodule

bind interval_timing_statistics its_chk u_its_chk (.*);
